>>> sv/fiti_pkg.sv
// ----------------------------------------------------------------------------
// fiti_pkg: shared types, constants and tables of the flare intensity block
// Holds the fixed-point formats, breakpoint tables, pipeline stage indexes
// and the reciprocal constants used by the interpolation units.
// ----------------------------------------------------------------------------
package fiti_pkg;

    localparam int CURVE_POINTS_DEF = 7;

    localparam int NUM_STAGES = 8;
    localparam int ST_FRONT   = 0;
    localparam int ST_SEG     = 1;
    localparam int ST_MUL     = 2;
    localparam int ST_RECIP   = 3;
    localparam int ST_RES     = 4;
    localparam int ST_PD      = 5;
    localparam int ST_PART    = 6;
    localparam int ST_OUT     = 7;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic dist_lo;
        logic dist_hi;
        logic ang_lo;
        logic ang_hi;
    } clamp_t;

    localparam int POWER_W   = 16;
    localparam int DIST_W    = 20;
    localparam int ANGLE_W   = 16;
    localparam int RATE_W    = 16;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    localparam int PR_W   = 17;
    localparam int TAB_W  = 19;
    localparam int DIFF_W = 20;
    localparam int IDX_W  = 4;

    localparam logic [POWER_W-1:0] POWER_ONE = 16'd4096;
    localparam logic [PR_W-1:0]    PR_ONE    = 17'h10000;

    localparam int                  DIST_X5_W   = 23;
    localparam logic [DIST_X5_W-1:0] DIST_LO_X5 = 23'd16384;
    localparam logic [DIST_W-1:0]    DIST_HI    = 20'd53248;
    localparam int DIST_DEN    = 249856;
    localparam int DIST_X_W    = 18;
    localparam int DIST_POS_W  = 22;
    localparam int DIST_FRAC_W = 18;
    localparam int DIST_SHIFT  = 12;
    localparam int DIST_V_W    = 25;
    localparam int DIST_M_W    = 26;
    localparam int DIST_R_SH   = 31;
    localparam int DIST_OFF_K  = 18;
    localparam int DIST_DIV    = DIST_DEN >> DIST_SHIFT;
    localparam longint unsigned DIST_RECIP =
        ((64'd1 << DIST_R_SH) + DIST_DIV - 1) / DIST_DIV;

    localparam logic signed [ANGLE_W-1:0] ANG_LO = 16'sd11152;
    localparam logic signed [ANGLE_W-1:0] ANG_HI = 16'sd23877;
    localparam int ANG_DEN    = 12725;
    localparam int ANG_X_W    = 14;
    localparam int ANG_POS_W  = 18;
    localparam int ANG_FRAC_W = 14;
    localparam int ANG_SHIFT  = 0;
    localparam int ANG_V_W    = 31;
    localparam int ANG_M_W    = 32;
    localparam int ANG_R_SH   = 45;
    localparam int ANG_OFF_K  = 16;
    localparam longint unsigned ANG_RECIP =
        ((64'd1 << ANG_R_SH) + ANG_DEN - 1) / ANG_DEN;

    localparam int RND_BIT = 33;
    localparam int RND_SH  = 34;
    localparam logic [RATE_W-1:0] RATE_MAX = 16'd32768;

    localparam logic [TAB_W-1:0] DIST_TAB [16] = '{
        19'd262144, 19'd85197, 19'd58982, 19'd45875, 19'd32768, 19'd22938,
        19'd13107,  19'd13107, 19'd13107, 19'd13107, 19'd13107, 19'd13107,
        19'd13107,  19'd13107, 19'd13107, 19'd13107
    };

    localparam logic [TAB_W-1:0] ANG_TAB [16] = '{
        19'd9830,  19'd13107, 19'd16384, 19'd19661, 19'd22938, 19'd32768,
        19'd85197, 19'd85197, 19'd85197, 19'd85197, 19'd85197, 19'd85197,
        19'd85197, 19'd85197, 19'd85197, 19'd85197
    };

    function automatic logic [TAB_W-1:0] tab_lookup(input logic is_angle,
                                                    input logic [IDX_W-1:0] idx);
        return is_angle ? ANG_TAB[idx] : DIST_TAB[idx];
    endfunction

endpackage

>>> sv/fiti_front.sv
// ----------------------------------------------------------------------------
// fiti_front: input stage of the flare intensity pipeline
// Registers the power rate, the clamp decisions and the scaled positions of
// distance and angle within their breakpoint ranges.
// ----------------------------------------------------------------------------
module fiti_front
    import fiti_pkg::*;
#(
    parameter int NSEG = CURVE_POINTS_DEF - 1
) (
    input  logic                         aclk,
    input  stage_en_t                    stage_en,
    input  logic [POWER_W-1:0]           light_power,
    input  logic [DIST_W-1:0]            distance,
    input  logic signed [ANGLE_W-1:0]    angle,
    output logic [PR_W-1:0]              power_gain,
    output logic [DIST_POS_W-1:0]        dist_pos,
    output logic [ANG_POS_W-1:0]         ang_pos,
    output clamp_t                       clamp
);

    logic [DIST_X5_W-1:0]       dist_x5;
    logic [DIST_X5_W-1:0]       dist_x5_off;
    logic [ANGLE_W-1:0]         ang_off;
    logic [PR_W-1:0]            power_gain_next;
    logic [DIST_POS_W-1:0]      dist_pos_next;
    logic [ANG_POS_W-1:0]       ang_pos_next;
    clamp_t                     clamp_next;
    logic [PR_W-1:0]            power_gain_reg;
    logic [DIST_POS_W-1:0]      dist_pos_reg;
    logic [ANG_POS_W-1:0]       ang_pos_reg;
    clamp_t                     clamp_reg;

    always_comb begin
        dist_x5     = {1'b0, distance, 2'b00} + {3'b000, distance};
        dist_x5_off = dist_x5 - DIST_LO_X5;
        ang_off     = angle - ANG_LO;

        power_gain_next = (light_power >= POWER_ONE) ? PR_ONE
                                                     : {1'b0, light_power[11:0], 4'b0000};

        clamp_next.dist_lo = (dist_x5 < DIST_LO_X5);
        clamp_next.dist_hi = (distance >= DIST_HI);
        clamp_next.ang_lo  = (angle < ANG_LO);
        clamp_next.ang_hi  = (angle >= ANG_HI);

        dist_pos_next = DIST_POS_W'({4'b0000, dist_x5_off[DIST_X_W-1:0]}
                                    * DIST_POS_W'(NSEG));
        ang_pos_next  = ANG_POS_W'({4'b0000, ang_off[ANG_X_W-1:0]}
                                   * ANG_POS_W'(NSEG));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_FRONT]) begin
            power_gain_reg <= power_gain_next;
            dist_pos_reg   <= dist_pos_next;
            ang_pos_reg    <= ang_pos_next;
            clamp_reg      <= clamp_next;
        end
    end

    assign power_gain = power_gain_reg;
    assign dist_pos   = dist_pos_reg;
    assign ang_pos    = ang_pos_reg;
    assign clamp      = clamp_reg;

endmodule

>>> sv/fiti_interp.sv
// ----------------------------------------------------------------------------
// fiti_interp: pipelined breakpoint interpolation unit
// Finds the segment, forms the weighted difference, divides it by the
// segment span through a reciprocal multiply and adds the base entry.
// ----------------------------------------------------------------------------
module fiti_interp
    import fiti_pkg::*;
#(
    parameter int              NSEG     = CURVE_POINTS_DEF - 1,
    parameter int              DEN      = DIST_DEN,
    parameter int              POS_W    = DIST_POS_W,
    parameter int              FRAC_W   = DIST_FRAC_W,
    parameter int              SHIFT    = DIST_SHIFT,
    parameter int              V_W      = DIST_V_W,
    parameter int              M_W      = DIST_M_W,
    parameter longint unsigned RECIP    = DIST_RECIP,
    parameter int              R_SH     = DIST_R_SH,
    parameter int              OFF_K    = DIST_OFF_K,
    parameter bit              IS_ANGLE = 1'b0
) (
    input  logic              aclk,
    input  stage_en_t         stage_en,
    input  logic [POS_W-1:0]  pos,
    input  logic              clamp_lo,
    input  logic              clamp_hi,
    output logic [TAB_W-1:0]  result
);

    localparam int     Z_W  = DIFF_W + FRAC_W + 1;
    localparam int     S_W  = Z_W + 1;
    localparam int     W_W  = V_W + SHIFT;
    localparam int     QM_W = V_W + M_W;
    localparam int     Q_W  = QM_W - R_SH;
    localparam int     R_W  = TAB_W + Q_W + 1;
    localparam longint OFFC = DEN / 2 + (longint'(DEN) <<< OFF_K);
    localparam longint QOFF = longint'(1) <<< OFF_K;

    logic [IDX_W-1:0]          seg;
    logic [POS_W-1:0]          base;
    logic [TAB_W-1:0]          t0_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [FRAC_W-1:0]         frac_next;
    logic [TAB_W-1:0]          t0_s2_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [FRAC_W-1:0]         frac_reg;

    logic signed [Z_W-1:0]     z_next;
    logic signed [Z_W-1:0]     z_reg;
    logic [TAB_W-1:0]          t0_s3_reg;

    logic signed [S_W-1:0]     w_sum;
    logic [W_W-1:0]            w_pos;
    logic [V_W-1:0]            v_val;
    logic [QM_W-1:0]           qm_next;
    logic [QM_W-1:0]           qm_reg;
    logic [TAB_W-1:0]          t0_s4_reg;

    logic [Q_W-1:0]            q_val;
    logic [R_W-1:0]            r_full;
    logic [TAB_W-1:0]          result_next;
    logic [TAB_W-1:0]          result_reg;

    // Segment search: the breakpoint compares are independent and monotone.
    always_comb begin
        seg  = '0;
        base = '0;
        for (int k = 1; k < NSEG; k++) begin
            if (pos >= POS_W'(k * DEN)) begin
                seg  = IDX_W'(k);
                base = POS_W'(k * DEN);
            end
        end

        if (clamp_hi) begin
            t0_next   = tab_lookup(IS_ANGLE, IDX_W'(NSEG));
            diff_next = '0;
            frac_next = '0;
        end else if (clamp_lo) begin
            t0_next   = tab_lookup(IS_ANGLE, '0);
            diff_next = '0;
            frac_next = '0;
        end else begin
            t0_next   = tab_lookup(IS_ANGLE, seg);
            diff_next = $signed({1'b0, tab_lookup(IS_ANGLE, IDX_W'(seg + 1'b1))})
                        - $signed({1'b0, t0_next});
            frac_next = FRAC_W'(pos - base);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_SEG]) begin
            t0_s2_reg <= t0_next;
            diff_reg  <= diff_next;
            frac_reg  <= frac_next;
        end
    end

    assign z_next = diff_reg * $signed({1'b0, frac_reg});

    always_ff @(posedge aclk) begin
        if (stage_en[ST_MUL]) begin
            z_reg     <= z_next;
            t0_s3_reg <= t0_s2_reg;
        end
    end

    // The offset keeps the dividend positive so that the quotient is a floor.
    always_comb begin
        w_sum   = z_reg + $signed(S_W'(OFFC));
        w_pos   = w_sum[W_W-1:0];
        v_val   = w_pos[W_W-1:SHIFT];
        qm_next = v_val * M_W'(RECIP);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_RECIP]) begin
            qm_reg    <= qm_next;
            t0_s4_reg <= t0_s3_reg;
        end
    end

    always_comb begin
        q_val       = qm_reg[QM_W-1:R_SH];
        r_full      = R_W'(t0_s4_reg) + R_W'(q_val) - R_W'(QOFF);
        result_next = r_full[TAB_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_RES]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> sv/fiti_mul.sv
// ----------------------------------------------------------------------------
// fiti_mul: product, rounding and saturation stages
// Multiplies the three partial rates over two registered steps and rounds
// the product to Q2.14, limited to 2.0.
// ----------------------------------------------------------------------------
module fiti_mul
    import fiti_pkg::*;
(
    input  logic               aclk,
    input  stage_en_t          stage_en,
    input  logic [PR_W-1:0]    power_gain,
    input  logic [TAB_W-1:0]   depth_gain,
    input  logic [TAB_W-1:0]   ang_rate,
    output logic [RATE_W-1:0]  rate
);

    localparam int PD_W   = PR_W + TAB_W;
    localparam int HALF_W = PD_W / 2;
    localparam int PART_W = HALF_W + TAB_W;
    localparam int PROD_W = PD_W + TAB_W;
    localparam int RND_W  = PROD_W - RND_SH;

    logic [PD_W-1:0]    pd_next;
    logic [PD_W-1:0]    pd_reg;
    logic [TAB_W-1:0]   ar_reg;
    logic [PART_W-1:0]  lo_next;
    logic [PART_W-1:0]  hi_next;
    logic [PART_W-1:0]  lo_reg;
    logic [PART_W-1:0]  hi_reg;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_rnd;
    logic [RND_W-1:0]   rnd;
    logic [RATE_W-1:0]  rate_next;
    logic [RATE_W-1:0]  rate_reg;

    assign pd_next = PD_W'(power_gain) * PD_W'(depth_gain);

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PD]) begin
            pd_reg <= pd_next;
            ar_reg <= ang_rate;
        end
    end

    assign lo_next = PART_W'(pd_reg[HALF_W-1:0]) * PART_W'(ar_reg);
    assign hi_next = PART_W'(pd_reg[PD_W-1:HALF_W]) * PART_W'(ar_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PART]) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_comb begin
        prod      = PROD_W'({hi_reg, {HALF_W{1'b0}}}) + PROD_W'(lo_reg);
        prod_rnd  = prod + (PROD_W'(1) << RND_BIT);
        rnd       = prod_rnd[PROD_W-1:RND_SH];
        rate_next = (rnd > RND_W'(RATE_MAX)) ? RATE_MAX : rnd[RATE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            rate_reg <= rate_next;
        end
    end

    assign rate = rate_reg;

endmodule

>>> sv/flare_intensity_table_interp.sv
// ----------------------------------------------------------------------------
// flare_intensity_table_interp: flare effect target rate
// Interpolates distance and angle through evenly spaced breakpoint tables,
// scales power and multiplies the three rates into a saturated Q2.14 result.
//
//   Channel  Direction  Payload (lowest bit first)
//   s_       in         light_power[15:0], distance[35:16], angle[51:36]
//   m_       out        rate[15:0]
//
// m_tvalid is the valid bit of the last stage, ST_OUT.
// One transaction is accepted every cycle unless a full pipeline is stalled;
// the eight-stage pipeline runs the two interpolation units in parallel.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stall on m_tready holds the full stages and lets empty stages fill,
// so s_tready stays high while any stage is free.
// ----------------------------------------------------------------------------
module flare_intensity_table_interp
    import fiti_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // light_power[15:0], distance[35:16], angle[51:36], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // rate[15:0]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int NSEG = CURVE_POINTS - 1;

    stage_en_t              stage_en;
    stage_en_t              valid_next;
    stage_en_t              valid_reg;
    logic [PR_W-1:0]        power_gain;
    logic [DIST_POS_W-1:0]  dist_pos;
    logic [ANG_POS_W-1:0]   ang_pos;
    clamp_t                 clamp;
    logic [PR_W-1:0]        pr_s2_reg;
    logic [PR_W-1:0]        pr_s3_reg;
    logic [PR_W-1:0]        pr_s4_reg;
    logic [PR_W-1:0]        pr_s5_reg;
    logic [TAB_W-1:0]       depth_gain;
    logic [TAB_W-1:0]       ang_rate;
    logic [RATE_W-1:0]      rate;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[ST_FRONT]) begin
            valid_next[ST_FRONT] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[ST_FRONT];
    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = rate;

    fiti_front #(
        .NSEG (NSEG)
    ) u_front (
        .aclk        (aclk),
        .stage_en    (stage_en),
        .light_power (s_tdata[15:0]),
        .distance    (s_tdata[35:16]),
        .angle       ($signed(s_tdata[51:36])),
        .power_gain  (power_gain),
        .dist_pos    (dist_pos),
        .ang_pos     (ang_pos),
        .clamp       (clamp)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[ST_SEG]) begin
            pr_s2_reg <= power_gain;
        end
        if (stage_en[ST_MUL]) begin
            pr_s3_reg <= pr_s2_reg;
        end
        if (stage_en[ST_RECIP]) begin
            pr_s4_reg <= pr_s3_reg;
        end
        if (stage_en[ST_RES]) begin
            pr_s5_reg <= pr_s4_reg;
        end
    end

    fiti_interp #(
        .NSEG     (NSEG),
        .DEN      (DIST_DEN),
        .POS_W    (DIST_POS_W),
        .FRAC_W   (DIST_FRAC_W),
        .SHIFT    (DIST_SHIFT),
        .V_W      (DIST_V_W),
        .M_W      (DIST_M_W),
        .RECIP    (DIST_RECIP),
        .R_SH     (DIST_R_SH),
        .OFF_K    (DIST_OFF_K),
        .IS_ANGLE (1'b0)
    ) u_interp_dist (
        .aclk     (aclk),
        .stage_en (stage_en),
        .pos      (dist_pos),
        .clamp_lo (clamp.dist_lo),
        .clamp_hi (clamp.dist_hi),
        .result   (depth_gain)
    );

    fiti_interp #(
        .NSEG     (NSEG),
        .DEN      (ANG_DEN),
        .POS_W    (ANG_POS_W),
        .FRAC_W   (ANG_FRAC_W),
        .SHIFT    (ANG_SHIFT),
        .V_W      (ANG_V_W),
        .M_W      (ANG_M_W),
        .RECIP    (ANG_RECIP),
        .R_SH     (ANG_R_SH),
        .OFF_K    (ANG_OFF_K),
        .IS_ANGLE (1'b1)
    ) u_interp_ang (
        .aclk     (aclk),
        .stage_en (stage_en),
        .pos      (ang_pos),
        .clamp_lo (clamp.ang_lo),
        .clamp_hi (clamp.ang_hi),
        .result   (ang_rate)
    );

    fiti_mul u_mul (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .power_gain (pr_s5_reg),
        .depth_gain (depth_gain),
        .ang_rate   (ang_rate),
        .rate       (rate)
    );

    a_accept_fills_front: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[ST_FRONT])
        else $error("Accepted transaction did not enter the first stage.");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("Input stalled while a pipeline stage was empty.");

    a_full_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_tready |=> (&valid_reg))
        else $error("Stalled full pipeline lost a transaction.");

    a_rate_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= RATE_MAX)
        else $error("Output rate exceeds 2.0.");

endmodule
